@@ rtl/assert_macros.svh @@
// Assertion macros shared by the pulse width decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define PW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse width decoder: same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define PW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse width decoder: next-cycle check failed");
`else
`define PW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define PW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/pwwsd_pkg.sv @@
// Shared types and constants of the pulse width weather sensor decoder.
package pwwsd_pkg;

    localparam int TIME_BITS      = 32;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int PCOUNT_W       = 4;
    localparam int BCOUNT_W       = 6;
    localparam int WORD_BITS      = 40;

    localparam logic [PCOUNT_W-1:0] PREAMBLE_EDGES = 4'd8;
    localparam logic [BCOUNT_W-1:0] PACKET_BITS    = 6'd40;

    // Temperature conversion: (raw - 900 - 320) * 10 / 18, i.e. times 5 over 9.
    localparam logic signed [12:0] TEMP_OFFSET = 13'sd1220;
    localparam logic [16:0]        DIV9_RECIP  = 17'd58255;
    localparam int                 DIV9_SHIFT  = 19;
    localparam logic [7:0]         HUM_MAX     = 8'd100;

    typedef enum logic [3:0] {
        ST_WAIT         = 4'd0,
        ST_CHECK_SYNC   = 4'd1,
        ST_SYNC_OK      = 4'd2,
        ST_BAD_SYNC     = 4'd3,
        ST_BAD_HIGH     = 4'd4,
        ST_FALLING_OK   = 4'd5,
        ST_BAD_LOW      = 4'd6,
        ST_NEXT_BIT     = 4'd7,
        ST_BAD_SUM      = 4'd8,
        ST_BAD_HUMIDITY = 4'd9,
        ST_PACKET_OK    = 4'd10
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_MIN      = 3'd0,
        CFG_SYNC_MAX      = 3'd1,
        CFG_PULSE_MIN     = 3'd2,
        CFG_PULSE_MAX     = 3'd3,
        CFG_ONE_THRESHOLD = 3'd4,
        CFG_SHORT_LOW_MAX = 3'd5,
        CFG_LONG_LOW_MIN  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] sync_min;
        logic [CFG_DATA_W-1:0] sync_max;
        logic [CFG_DATA_W-1:0] pulse_min;
        logic [CFG_DATA_W-1:0] pulse_max;
        logic [CFG_DATA_W-1:0] one_threshold;
        logic [CFG_DATA_W-1:0] short_low_max;
        logic [CFG_DATA_W-1:0] long_low_min;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic               packet_valid;
        logic [7:0]         sensor_id;
        logic [2:0]         channel;
        logic               batt_low;
        logic [6:0]         humidity;
        logic signed [11:0] temperature;
    } t_result;

endpackage

@@ rtl/pwwsd_in_if.sv @@
// Request channel carrying one radio edge event.
interface pwwsd_in_if;
    import pwwsd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 edge_rising;
    logic [TIME_BITS-1:0] timestamp;

    modport source (output valid, output edge_rising, output timestamp, input ready);
    modport sink   (input valid, input edge_rising, input timestamp, output ready);
endinterface

@@ rtl/pwwsd_out_if.sv @@
// Request channel carrying one decode status with any packet fields.
interface pwwsd_out_if;
    import pwwsd_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic               packet_valid;
    logic [7:0]         sensor_id;
    logic [2:0]         channel;
    logic               batt_low;
    logic [6:0]         humidity;
    logic signed [11:0] temperature;

    modport source (output valid, output status, output packet_valid, output sensor_id,
                    output channel, output batt_low, output humidity,
                    output temperature, input ready);
    modport sink   (input valid, input status, input packet_valid, input sensor_id,
                    input channel, input batt_low, input humidity,
                    input temperature, output ready);
endinterface

@@ rtl/pwwsd_cfg_regs.sv @@
// Timing threshold registers written through the configuration port.
module pwwsd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [pwwsd_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [pwwsd_pkg::CFG_DATA_W-1:0] i_data,
    output pwwsd_pkg::t_cfg                  o_cfg
);
    import pwwsd_pkg::*;

    t_cfg r_cfg;

    // Reset loads the default thresholds; a write to an unused index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_min      <= 16'd700;
            r_cfg.sync_max      <= 16'd900;
            r_cfg.pulse_min     <= 16'd200;
            r_cfg.pulse_max     <= 16'd600;
            r_cfg.one_threshold <= 16'd400;
            r_cfg.short_low_max <= 16'd300;
            r_cfg.long_low_min  <= 16'd400;
        end else if (i_we) begin
            case (i_index)
                CFG_SYNC_MIN:      r_cfg.sync_min      <= i_data;
                CFG_SYNC_MAX:      r_cfg.sync_max      <= i_data;
                CFG_PULSE_MIN:     r_cfg.pulse_min     <= i_data;
                CFG_PULSE_MAX:     r_cfg.pulse_max     <= i_data;
                CFG_ONE_THRESHOLD: r_cfg.one_threshold <= i_data;
                CFG_SHORT_LOW_MAX: r_cfg.short_low_max <= i_data;
                CFG_LONG_LOW_MIN:  r_cfg.long_low_min  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/pwwsd_packet_check.sv @@
// Sum check, humidity limit and field extraction for a completed 40-bit word.
module pwwsd_packet_check (
    input  logic [pwwsd_pkg::WORD_BITS-1:0] i_word,
    output pwwsd_pkg::t_result              o_result
);
    import pwwsd_pkg::*;

    logic [7:0]         b0, b1, b2, b3, b4;
    logic [7:0]         sum;
    logic [11:0]        raw;
    logic signed [12:0] diff;
    logic signed [14:0] diff_x;
    logic signed [14:0] diff5;
    logic [13:0]        mag;
    logic [30:0]        prod;
    logic [10:0]        quo;
    logic signed [11:0] temp;

    // Byte 0 is the last byte received, byte 4 the first.
    assign b0  = i_word[7:0];
    assign b1  = i_word[15:8];
    assign b2  = i_word[23:16];
    assign b3  = i_word[31:24];
    assign b4  = i_word[39:32];
    assign sum = b1 + b2 + b3 + b4;

    // Temperature: scale by five by shift and add, then divide the magnitude
    // by nine with a reciprocal multiply, and restore the sign so the
    // quotient truncates toward zero.
    assign raw    = {b3[3:0], b2};
    assign diff   = $signed({1'b0, raw}) - TEMP_OFFSET;
    assign diff_x = $signed({{2{diff[12]}}, diff});
    assign diff5  = (diff_x <<< 2) + diff_x;
    assign mag    = diff5[14] ? 14'(-diff5) : 14'(diff5);
    assign prod   = 31'(mag) * 31'(DIV9_RECIP);
    assign quo    = prod[DIV9_SHIFT +: 11];
    assign temp   = diff5[14] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    // Fields are only reported for a packet that passes both checks.
    always_comb begin
        o_result = '0;
        if (sum != b0) begin
            o_result.status = ST_BAD_SUM;
        end else if (b1 > HUM_MAX) begin
            o_result.status = ST_BAD_HUMIDITY;
        end else begin
            o_result.status       = ST_PACKET_OK;
            o_result.packet_valid = 1'b1;
            o_result.sensor_id    = b4;
            o_result.channel      = b3[6:4];
            o_result.batt_low     = b3[7];
            o_result.humidity     = b1[6:0];
            o_result.temperature  = temp;
        end
    end

endmodule

@@ rtl/pwwsd_edge_ctrl.sv @@
// Per-edge gap measurement, preamble tracking and bit reception.
module pwwsd_edge_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pwwsd_pkg::t_cfg                 i_cfg,
    input  logic                            i_step,
    input  logic                            i_rising,
    input  logic [pwwsd_pkg::TIME_BITS-1:0] i_time,
    output pwwsd_pkg::t_result              o_result
);
    import pwwsd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE     = 3'b001,
        S_PREAMBLE = 3'b010,
        S_BITS     = 3'b100
    } t_state;

    t_state                r_state,  n_state;
    logic [TIME_BITS-1:0]  r_last;
    logic [PCOUNT_W-1:0]   r_pcount, n_pcount;
    logic [BCOUNT_W-1:0]   r_bcount, n_bcount;
    logic                  r_expect, n_expect;
    logic [WORD_BITS-1:0]  r_word,   n_word;

    logic [TIME_BITS-1:0]  delta;
    logic                  sync_ok, high_ok, low_ok;
    logic [PCOUNT_W-1:0]   pcount_inc;
    logic [BCOUNT_W-1:0]   bcount_inc;
    logic [WORD_BITS-1:0]  word_shift;
    logic                  packet_done;
    t_status               status;
    t_result               pkt_result;

    // Gap since the previous edge, wrapping with the timestamp.
    assign delta = i_time - r_last;

    assign sync_ok = (delta >= TIME_BITS'(i_cfg.sync_min))
                  && (delta <= TIME_BITS'(i_cfg.sync_max));
    assign high_ok = (delta >= TIME_BITS'(i_cfg.pulse_min))
                  && (delta <= TIME_BITS'(i_cfg.pulse_max));
    // After a one the low time is short, after a zero it is long.
    assign low_ok  = r_expect
        ? ((delta >= TIME_BITS'(i_cfg.pulse_min))
           && (delta <= TIME_BITS'(i_cfg.short_low_max)))
        : ((delta >= TIME_BITS'(i_cfg.long_low_min))
           && (delta <= TIME_BITS'(i_cfg.pulse_max)));

    assign pcount_inc = r_pcount + 1'b1;
    assign bcount_inc = r_bcount + 1'b1;
    assign word_shift = {r_word[WORD_BITS-2:0], r_expect};

    pwwsd_packet_check u_packet_check (
        .i_word   (word_shift),
        .o_result (pkt_result)
    );

    // Next state and status for the edge being decoded.
    always_comb begin
        n_state     = r_state;
        n_pcount    = r_pcount;
        n_bcount    = r_bcount;
        n_expect    = r_expect;
        n_word      = r_word;
        status      = ST_WAIT;
        packet_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_rising) begin
                    n_state  = S_PREAMBLE;
                    n_pcount = '0;
                    status   = ST_CHECK_SYNC;
                end
            end
            S_PREAMBLE: begin
                if (!sync_ok) begin
                    n_state = S_IDLE;
                    status  = ST_BAD_SYNC;
                end else if (pcount_inc >= PREAMBLE_EDGES) begin
                    n_state  = S_BITS;
                    n_pcount = '0;
                    n_bcount = '0;
                    status   = ST_SYNC_OK;
                end else begin
                    n_pcount = pcount_inc;
                end
            end
            S_BITS: begin
                if (!i_rising) begin
                    if (!high_ok) begin
                        n_state = S_IDLE;
                        status  = ST_BAD_HIGH;
                    end else begin
                        n_expect = delta >= TIME_BITS'(i_cfg.one_threshold);
                        status   = ST_FALLING_OK;
                    end
                end else if (!low_ok) begin
                    n_state = S_IDLE;
                    status  = ST_BAD_LOW;
                end else begin
                    n_word   = word_shift;
                    n_bcount = bcount_inc;
                    if (bcount_inc >= PACKET_BITS) begin
                        n_state     = S_IDLE;
                        packet_done = 1'b1;
                    end else begin
                        status = ST_NEXT_BIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The last bit of a packet reports the packet check; every other edge
    // reports its status alone.
    always_comb begin
        if (packet_done) begin
            o_result = pkt_result;
        end else begin
            o_result        = '0;
            o_result.status = status;
        end
    end

    // Decoder state advances once per decoded edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= '0;
            r_pcount <= '0;
            r_bcount <= '0;
            r_expect <= 1'b0;
            r_word   <= '0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_last   <= i_time;
            r_pcount <= n_pcount;
            r_bcount <= n_bcount;
            r_expect <= n_expect;
            r_word   <= n_word;
        end
    end

endmodule

@@ rtl/pulse_width_weather_sensor_decoder.sv @@
// Top level of the pulse width weather sensor decoder.
// An accepted edge request is held in the edge register, then decoded into
// the result register, which offers the result. Throughput: one edge per cycle
// while results are taken; each edge makes one pass through the decode logic.
// Reset (synchronous, active low) clears the decoder state, empties both
// registers and loads the default thresholds.
`include "assert_macros.svh"

module pulse_width_weather_sensor_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pwwsd_in_if.sink                         i_edge,
    pwwsd_out_if.source                      o_result,
    input  logic                             i_cfg_we,
    input  logic [pwwsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pwwsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pwwsd_pkg::*;

    t_cfg                 cfg;
    t_result              result;

    logic                 r_in_valid;
    logic                 r_in_rising;
    logic [TIME_BITS-1:0] r_in_time;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_out_free;
    logic                 w_advance;
    logic                 w_in_accept;

    pwwsd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The edge register moves on whenever the result register is free or
    // being emptied, so an edge can enter every cycle while results are taken.
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_advance    = r_in_valid && w_out_free;
    assign i_edge.ready = !r_in_valid || w_out_free;
    assign w_in_accept  = i_edge.valid && i_edge.ready;

    pwwsd_edge_ctrl u_edge_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (w_advance),
        .i_rising (r_in_rising),
        .i_time   (r_in_time),
        .o_result (result)
    );

    // Edge register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_rising <= i_edge.edge_rising;
            r_in_time   <= i_edge.timestamp;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out.status;
    assign o_result.packet_valid = r_out.packet_valid;
    assign o_result.sensor_id    = r_out.sensor_id;
    assign o_result.channel      = r_out.channel;
    assign o_result.batt_low     = r_out.batt_low;
    assign o_result.humidity     = r_out.humidity;
    assign o_result.temperature  = r_out.temperature;

    // A packet flag goes with the packet status and nothing else.
    `PW_ASSERT_IMPLIES(a_pkt_flag, i_clk, i_rst_n, r_out_valid,
        r_out.packet_valid == (r_out.status == ST_PACKET_OK))
    // Without a packet the reported fields are zero.
    `PW_ASSERT_IMPLIES(a_fields_zero, i_clk, i_rst_n, r_out_valid && !r_out.packet_valid,
        r_out.sensor_id == 8'd0 && r_out.humidity == 7'd0 && r_out.temperature == 12'sd0)
    // A decoded edge always lands in the result register.
    `PW_ASSERT_NEXT(a_advance_lands, i_clk, i_rst_n, w_advance, r_out_valid)
    // A held edge is neither lost nor overwritten.
    `PW_ASSERT_NEXT(a_edge_held, i_clk, i_rst_n, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in_time))

endmodule
